### rtl/cfpa_pkg.sv
`timescale 1ns / 1ps

package cfpa_pkg;

  typedef enum logic [2:0] {
    K_ADD = 3'd0,
    K_SUB = 3'd1,
    K_MUL = 3'd2,
    K_DIV = 3'd3,
    K_NEG = 3'd4,
    K_POW = 3'd5,
    K_CMP = 3'd6
  } kind_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  localparam logic signed [65:0] SAT_MAX = 66'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [65:0] SAT_MIN = -66'sh0_0000_0000_8000_0000;

  // Clamp a wide signed value to 32-bit signed.
  function automatic sat_t sat_s66(input logic signed [65:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/complex_fixed_point_alu_core.sv
`timescale 1ns / 1ps

// Complex fixed-point ALU (signed Q(32-FRAC_BITS).FRAC_BITS operands).
// Input channel: in_valid/in_ready carries kind, a, b and exponent; one
// request gives exactly one result on the out_valid/out_ready channel.
// One request is worked at a time; in_ready is high only when the
// sequencer is idle. All products come from one shared 32x32 multiplier,
// one product per cycle, and divide uses a one-bit-per-cycle restoring
// divider that produces 33 quotient bits per result part.
// Path from accept to result register:
//   add, sub, negate, unused code, power with exponent 0: straight to S_DONE
//   multiply, compare: one product pass (S_MUL, then S_POST)
//   power: one product pass per exponent step (exponent clamped to MAX_EXPONENT)
//   divide: two product passes and two 33-step divisions, or only the first
//   product pass when the divisor is zero
// The result sits in an output register; the core accepts the next request
// while that result waits. If the receiver stalls and the output register
// is still full when the next result is done, the core holds that result
// and stays busy until the register frees up.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.

module complex_fixed_point_alu_core #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_EXPONENT = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic [3:0]         in_exponent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_div_zero,
  output logic               out_overflowed,
  output logic               out_is_equal,
  output logic               out_is_greater,
  output logic               out_is_less
);
  import cfpa_pkg::*;

  localparam int NW = 64 + FRAC_BITS;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_POST, S_DCHK, S_DRUN, S_DEND, S_DONE
  } state_t;

  state_t state_r;
  kind_t  kind_r;
  logic signed [31:0] ar_r, ai_r, br_r, bi_r, pr_r, pi_r;
  logic [5:0]  cnt_r;
  logic [2:0]  step_r;
  logic        pass2_r;
  logic signed [63:0] prod_r;
  logic        psub_r;
  logic signed [65:0] s0_r, s1_r;
  logic [63:0] den_r;
  logic [64:0] rem_r;
  logic [32:0] nsh_r, q_r;
  logic        neg_r, big_r;
  logic [5:0]  dcnt_r;
  logic [31:0] res_re_r, res_im_r;
  logic        ovf_r, dz_r, eq_r, gt_r, lt_r;
  logic        out_valid_r;
  logic [31:0] out_re_r, out_im_r;
  logic        out_dz_r, out_ovf_r, out_eq_r, out_gt_r, out_lt_r;

  // operand select for the shared multiplier
  logic signed [31:0] mx, my;
  logic               msub;
  always_comb begin
    mx   = ar_r;
    my   = br_r;
    msub = 1'b0;
    case (kind_r)
      K_MUL: begin
        case (step_r[1:0])
          2'd0: begin mx = ar_r; my = br_r; end
          2'd1: begin mx = ai_r; my = bi_r; msub = 1'b1; end
          2'd2: begin mx = ar_r; my = bi_r; end
          default: begin mx = ai_r; my = br_r; end
        endcase
      end
      K_POW: begin
        case (step_r[1:0])
          2'd0: begin mx = pr_r; my = ar_r; end
          2'd1: begin mx = pi_r; my = ai_r; msub = 1'b1; end
          2'd2: begin mx = pr_r; my = ai_r; end
          default: begin mx = pi_r; my = ar_r; end
        endcase
      end
      K_DIV: begin
        if (pass2_r) begin
          case (step_r[1:0])
            2'd0, 2'd2: begin mx = ai_r; my = br_r; end
            default: begin mx = ar_r; my = bi_r; msub = 1'b1; end
          endcase
        end else begin
          case (step_r[1:0])
            2'd0: begin mx = br_r; my = br_r; end
            2'd1: begin mx = bi_r; my = bi_r; end
            2'd2: begin mx = ar_r; my = br_r; end
            default: begin mx = ai_r; my = bi_r; end
          endcase
        end
      end
      default: begin
        case (step_r[1:0])
          2'd0: begin mx = ar_r; my = ar_r; end
          2'd1: begin mx = ai_r; my = ai_r; end
          2'd2: begin mx = br_r; my = br_r; end
          default: begin mx = bi_r; my = bi_r; end
        endcase
      end
    endcase
  end

  logic signed [63:0] prod_nxt;
  assign prod_nxt = 64'(mx) * 64'(my);

  logic signed [65:0] prod_x, acc_nxt;
  logic [2:0]         pidx;
  assign prod_x = 66'(prod_r);
  assign pidx   = step_r - 3'd1;
  always_comb begin
    if (!pidx[0]) begin
      acc_nxt = prod_x;
    end else if (pidx[1]) begin
      acc_nxt = psub_r ? s1_r - prod_x : s1_r + prod_x;
    end else begin
      acc_nxt = psub_r ? s0_r - prod_x : s0_r + prod_x;
    end
  end

  // fast ops at accept
  sat_t add_re, add_im;
  always_comb begin
    case (kind_t'(in_kind))
      K_ADD: begin
        add_re = sat_s66(66'(in_a_re) + 66'(in_b_re));
        add_im = sat_s66(66'(in_a_im) + 66'(in_b_im));
      end
      K_SUB: begin
        add_re = sat_s66(66'(in_a_re) - 66'(in_b_re));
        add_im = sat_s66(66'(in_a_im) - 66'(in_b_im));
      end
      default: begin
        add_re = sat_s66(-66'(in_a_re));
        add_im = sat_s66(-66'(in_a_im));
      end
    endcase
  end

  logic [5:0] ex_clamp;
  assign ex_clamp = ({2'b00, in_exponent} > 6'(MAX_EXPONENT)) ?
                    6'(MAX_EXPONENT) : {2'b00, in_exponent};

  // product post-processing: floor shift, then clamp
  sat_t mre, mim;
  assign mre = sat_s66(s0_r >>> FRAC_BITS);
  assign mim = sat_s66(s1_r >>> FRAC_BITS);

  // divider setup
  logic signed [65:0] num;
  logic               num_neg;
  logic [63:0]        mag;
  logic [NW-1:0]      nfull;
  logic               big_nxt;
  assign num     = pass2_r ? s0_r : s1_r;
  assign num_neg = num[65];
  assign mag     = num_neg ? 64'(-num) : num[63:0];
  assign nfull   = {mag, {FRAC_BITS{1'b0}}};
  // quotient needs more than 33 bits
  assign big_nxt = {{(33 - FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}} >=
                   {den_r, 33'd0};

  logic [64:0] r2;
  logic        qbit;
  assign r2   = {rem_r[63:0], nsh_r[32]};
  assign qbit = r2 >= {1'b0, den_r};

  logic        dneg;
  logic [31:0] dval;
  logic        dovf;
  always_comb begin
    dneg = neg_r && (big_r || (q_r != 33'd0));
    dovf = 1'b0;
    dval = q_r[31:0];
    if (!dneg) begin
      if (big_r || q_r[32] || q_r[31]) begin
        dval = 32'h7FFF_FFFF;
        dovf = 1'b1;
      end
    end else if (big_r || (q_r > 33'h0_8000_0000)) begin
      dval = 32'h8000_0000;
      dovf = 1'b1;
    end else begin
      dval = 32'(-q_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= kind_t'(in_kind);
            ar_r     <= in_a_re;
            ai_r     <= in_a_im;
            br_r     <= in_b_re;
            bi_r     <= in_b_im;
            pr_r     <= ONE_FX;
            pi_r     <= '0;
            cnt_r    <= ex_clamp;
            step_r   <= '0;
            pass2_r  <= 1'b0;
            dz_r     <= 1'b0;
            eq_r     <= (in_a_re == in_b_re) && (in_a_im == in_b_im) &&
                        (kind_t'(in_kind) == K_CMP);
            gt_r     <= 1'b0;
            lt_r     <= 1'b0;
            case (kind_t'(in_kind))
              K_ADD, K_SUB, K_NEG: begin
                res_re_r <= add_re.val;
                res_im_r <= add_im.val;
                ovf_r    <= add_re.ovf | add_im.ovf;
                state_r  <= S_DONE;
              end
              K_POW: begin
                res_re_r <= ONE_FX;
                res_im_r <= '0;
                ovf_r    <= 1'b0;
                state_r  <= (ex_clamp == 6'd0) ? S_DONE : S_MUL;
              end
              K_MUL, K_DIV, K_CMP: begin
                res_re_r <= '0;
                res_im_r <= '0;
                ovf_r    <= 1'b0;
                state_r  <= S_MUL;
              end
              default: begin
                res_re_r <= '0;
                res_im_r <= '0;
                ovf_r    <= 1'b0;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          psub_r <= msub;
          if (step_r != 3'd0) begin
            if (pidx[1]) s1_r <= acc_nxt;
            else s0_r <= acc_nxt;
          end
          if (step_r == 3'd4) state_r <= S_POST;
          else step_r <= step_r + 3'd1;
        end
        S_POST: begin
          step_r <= '0;
          case (kind_r)
            K_MUL: begin
              res_re_r <= mre.val;
              res_im_r <= mim.val;
              ovf_r    <= mre.ovf | mim.ovf;
              state_r  <= S_DONE;
            end
            K_POW: begin
              pr_r  <= mre.val;
              pi_r  <= mim.val;
              ovf_r <= ovf_r | mre.ovf | mim.ovf;
              cnt_r <= cnt_r - 6'd1;
              if (cnt_r == 6'd1) begin
                res_re_r <= mre.val;
                res_im_r <= mim.val;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_MUL;
              end
            end
            K_DIV: begin
              if (pass2_r) begin
                state_r <= S_DCHK;
              end else if (s0_r == 66'sd0) begin
                dz_r    <= 1'b1;
                state_r <= S_DONE;
              end else begin
                den_r   <= s0_r[63:0];
                state_r <= S_DCHK;
              end
            end
            default: begin
              gt_r    <= s0_r > s1_r;
              lt_r    <= s0_r < s1_r;
              state_r <= S_DONE;
            end
          endcase
        end
        S_DCHK: begin
          neg_r   <= num_neg;
          big_r   <= big_nxt;
          rem_r   <= 65'(nfull[NW-1:33]);
          nsh_r   <= nfull[32:0];
          q_r     <= '0;
          dcnt_r  <= '0;
          state_r <= S_DRUN;
        end
        S_DRUN: begin
          rem_r  <= qbit ? r2 - {1'b0, den_r} : r2;
          q_r    <= {q_r[31:0], qbit};
          nsh_r  <= {nsh_r[31:0], 1'b0};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd32) state_r <= S_DEND;
        end
        S_DEND: begin
          ovf_r <= ovf_r | dovf;
          if (pass2_r) begin
            res_im_r <= dval;
            state_r  <= S_DONE;
          end else begin
            res_re_r <= dval;
            pass2_r  <= 1'b1;
            step_r   <= '0;
            state_r  <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_re_r    <= res_re_r;
            out_im_r    <= res_im_r;
            out_dz_r    <= dz_r;
            out_ovf_r   <= ovf_r;
            out_eq_r    <= eq_r;
            out_gt_r    <= gt_r;
            out_lt_r    <= lt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_re     = out_re_r;
  assign out_res_im     = out_im_r;
  assign out_div_zero   = out_dz_r;
  assign out_overflowed = out_ovf_r;
  assign out_is_equal   = out_eq_r;
  assign out_is_greater = out_gt_r;
  assign out_is_less    = out_lt_r;

endmodule

### tb/complex_fixed_point_alu_checker.sv
`timescale 1ns / 1ps

module complex_fixed_point_alu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic [3:0]         in_exponent,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_res_re,
  input  logic signed [31:0] out_res_im,
  input  logic               out_div_zero,
  input  logic               out_overflowed,
  input  logic               out_is_equal,
  input  logic               out_is_greater,
  input  logic               out_is_less,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen
);
  import cfpa_pkg::*;

  localparam int FRAC = 16;
  localparam int MAX_EXP = 15;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ovf;
    logic        eq;
    logic        gt;
    logic        lt;
  } alu_result_t;

  alu_result_t expected_results[$];

  // clamp to 32-bit signed, flag on saturation
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void cplx_mul(input logic signed [31:0] xr, xi, yr, yi,
                                   output logic [31:0] rr, ri, inout logic ovf);
    logic signed [127:0] sr, si;
    sr = (128'(xr) * 128'(yr) - 128'(xi) * 128'(yi)) >>> FRAC;
    si = (128'(xr) * 128'(yi) + 128'(xi) * 128'(yr)) >>> FRAC;
    rr = clamp32(sr, ovf);
    ri = clamp32(si, ovf);
  endfunction

  function automatic logic [31:0] div_part(input logic signed [127:0] num,
                                           input logic signed [127:0] den, inout logic ovf);
    logic signed [127:0] q;
    // SV signed divide truncates toward zero
    q = (num <<< FRAC) / den;
    return clamp32(q, ovf);
  endfunction

  function automatic alu_result_t predict_alu(input logic [2:0] kind,
      input logic signed [31:0] ar, ai, br, bi, input logic [3:0] ex);
    alu_result_t r;
    logic signed [127:0] den, ma, mb;
    logic [31:0] accr, acci;
    r = '0;
    case (kind)
      K_ADD: begin
        r.re = clamp32(128'(ar) + 128'(br), r.ovf);
        r.im = clamp32(128'(ai) + 128'(bi), r.ovf);
      end
      K_SUB: begin
        r.re = clamp32(128'(ar) - 128'(br), r.ovf);
        r.im = clamp32(128'(ai) - 128'(bi), r.ovf);
      end
      K_MUL: cplx_mul(ar, ai, br, bi, r.re, r.im, r.ovf);
      K_DIV: begin
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = div_part(128'(ar) * 128'(br) + 128'(ai) * 128'(bi), den, r.ovf);
          r.im = div_part(128'(ai) * 128'(br) - 128'(ar) * 128'(bi), den, r.ovf);
        end
      end
      K_NEG: begin
        r.re = clamp32(-128'(ar), r.ovf);
        r.im = clamp32(-128'(ai), r.ovf);
      end
      K_POW: begin
        accr = 32'(1) << FRAC;
        acci = '0;
        for (int i = 0; i < ((ex > MAX_EXP) ? MAX_EXP : ex); i++)
          cplx_mul(accr, acci, ar, ai, accr, acci, r.ovf);
        r.re = accr;
        r.im = acci;
      end
      K_CMP: begin
        ma = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
        mb = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        r.eq = (ar == br) && (ai == bi);
        r.gt = ma > mb;
        r.lt = ma < mb;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst_n) begin
      mismatches <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(predict_alu(in_kind, in_a_re, in_a_im,
                                               in_b_re, in_b_im, in_exponent));
      if (out_valid && out_ready) begin
        got = {out_res_re, out_res_im, out_div_zero, out_overflowed,
               out_is_equal, out_is_greater, out_is_less};
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: re %h/%h im %h/%h dz %b/%b ovf %b/%b eq %b/%b gt %b/%b lt %b/%b",
                       want.re, got.re, want.im, got.im, want.dz, got.dz,
                       want.ovf, got.ovf, want.eq, got.eq, want.gt, got.gt,
                       want.lt, got.lt);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/complex_fixed_point_alu_core_test.sv
`timescale 1ns / 1ps

module complex_fixed_point_alu_core_test;
  import cfpa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic signed [31:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic [3:0] in_exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_re, out_res_im;
  logic out_div_zero, out_overflowed, out_is_equal, out_is_greater, out_is_less;
  int mismatches, pending, results_seen;
  int send_idle_pct = 11, recv_idle_pct = 80;
  int stall_cycles = 0;
  int requests_sent = 0;
  bit timed_out = 1'b0;

  always #5 clk = ~clk;

  complex_fixed_point_alu_core dut (.*);

  complex_fixed_point_alu_checker chk (.*);

  // receiver backpressure
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4, 5: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      6: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  // valid stays high after accept until the next call or an explicit drop
  task automatic send_request(input logic [2:0] k, input logic [31:0] ar, ai, br, bi,
                              input logic [3:0] ex);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    in_exponent <= ex;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random();
    logic [2:0] k;
    logic [31:0] ar, br;
    k = 3'($urandom_range(7));
    ar = pick_value();
    br = ($urandom_range(9) == 0) ? ar : pick_value();
    send_request(k, ar, pick_value(), br, pick_value(), 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send_request(K_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 4'd0);
    send_request(K_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 4'd0);
    send_request(K_MUL, 32'h0002_0000, 32'hFFFF_8000, 32'h0003_0000, 32'h0001_0000, 4'd0);
    send_request(K_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0);
    send_request(K_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 4'd0);
    send_request(K_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 4'd0);
    send_request(K_DIV, 32'h0005_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0002_0000, 4'd0);
    send_request(K_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 4'd0);
    send_request(K_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0, 4'd0);
    send_request(K_DIV, 32'hFFFE_0000, 32'h0, 32'h1, 32'h0, 4'd0);
    send_request(K_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234, 32'h0, 4'd0);
    send_request(K_POW, 32'h0001_8000, 32'h0000_4000, 32'h0, 32'h0, 4'd0);
    send_request(K_POW, 32'h0001_8000, 32'h0000_4000, 32'h0, 32'h0, 4'd15);
    send_request(K_POW, 32'h0000_F000, 32'h0000_1000, 32'hFFFF, 32'h1, 4'd7);
    send_request(K_CMP, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 4'd0);
    send_request(K_CMP, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 4'd0);
    send_request(K_CMP, 32'h0, 32'h1, 32'h0, 32'h8000_0000, 4'd0);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    // hold off until the pipe drains
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) begin
      send_random();
    end
    send_idle_pct = 80;
    recv_idle_pct = 11;
    repeat (300) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (300) send_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests over all seven operations and the unused code;", requests_sent);
    $display("checked %0d results under three backpressure mixes.", results_seen);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/cfpa_pkg.sv
rtl/complex_fixed_point_alu_core.sv
tb/complex_fixed_point_alu_checker.sv
tb/complex_fixed_point_alu_core_test.sv
